// File: hw/rtl/vufc_pkg.sv
// Shared types, constants and fixed-point helpers of the variable-universe fuzzy controller.
`timescale 1ns / 1ps
`default_nettype none

package vufc_pkg;

    localparam int AXES  = 6;
    localparam int AX_IW = (AXES > 1) ? $clog2(AXES) : 1;

    localparam int DIV_NW = 61;
    localparam int DIV_DW = 32;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [3:0]  HORNER_TERMS = 4'd12;

    typedef logic signed [32:0] t_op;
    typedef logic signed [65:0] t_prod;
    typedef logic signed [67:0] t_wide;

    typedef struct packed {
        logic [2:0]         axis;
        logic signed [31:0] target_vel;
        logic signed [31:0] measured_vel;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         axis_out;
        logic signed [31:0] force_res;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
    } t_div_rsp;

    typedef enum logic [2:0] {
        CFG_GAMMA  = 3'd0,
        CFG_LAMBDA = 3'd1,
        CFG_SLOPE  = 3'd2,
        CFG_KI     = 3'd3,
        CFG_P0     = 3'd4,
        CFG_P1     = 3'd5,
        CFG_ISP    = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CALL_INIT,
        CALL_CE,
        CALL_CD,
        CALL_T1,
        CALL_T2
    } t_call;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_DMUL,
        ST_DUSE,
        ST_DSUM,
        ST_SQ,
        ST_SQUSE,
        ST_TMUL,
        ST_TUSE,
        ST_HMUL,
        ST_HREC,
        ST_HCORR,
        ST_EXPN,
        ST_EXPNUSE,
        ST_EXP_RET,
        ST_GMUL,
        ST_GUSE,
        ST_CDIV,
        ST_CRET,
        ST_TDIV,
        ST_TWAIT,
        ST_BMUL1,
        ST_BMUL2,
        ST_BUSE,
        ST_PMUL1,
        ST_PMUL2,
        ST_PUSE,
        ST_QWAIT,
        ST_KMUL,
        ST_KUSE,
        ST_DONE
    } t_state;

    localparam t_wide W_MAX = 68'sd2147483647;
    localparam t_wide W_MIN = -68'sd2147483648;

    // Round to nearest with ties away from zero, then drop 16 fraction bits.
    function automatic t_wide f_rnd16(input t_wide v);
        t_wide mag;
        mag = v[67] ? -v : v;
        mag = (mag + 68'sd32768) >>> 16;
        return v[67] ? -mag : mag;
    endfunction

    function automatic t_wide f_rnd30(input t_wide v);
        t_wide mag;
        mag = v[67] ? -v : v;
        mag = (mag + 68'sd536870912) >>> 30;
        return v[67] ? -mag : mag;
    endfunction

    function automatic logic signed [31:0] f_sat32(input t_wide v);
        logic signed [31:0] r;
        if (v > W_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < W_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Applies a sign to an unsigned quotient and saturates it to 32 bits signed.
    function automatic logic signed [31:0] f_sgn_sat(input logic [DIV_NW-1:0] q,
                                                    input logic neg);
        logic signed [31:0] r;
        if (neg) begin
            r = (q > DIV_NW'(64'd2147483648)) ? 32'sh8000_0000 : $signed(-q[31:0]);
        end else begin
            r = (q > DIV_NW'(64'd2147483647)) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
        end
        return r;
    endfunction

    // floor(2^32 / k), with 2^32 - 1 standing in for k equal to one.
    function automatic logic [31:0] f_recip(input logic [3:0] k);
        logic [31:0] r;
        case (k)
            4'd1:    r = 32'hFFFF_FFFF;
            4'd2:    r = 32'h8000_0000;
            4'd3:    r = 32'h5555_5555;
            4'd4:    r = 32'h4000_0000;
            4'd5:    r = 32'h3333_3333;
            4'd6:    r = 32'h2AAA_AAAA;
            4'd7:    r = 32'h2492_4924;
            4'd8:    r = 32'h2000_0000;
            4'd9:    r = 32'h1C71_C71C;
            4'd10:   r = 32'h1999_9999;
            4'd11:   r = 32'h1745_D174;
            4'd12:   r = 32'h1555_5555;
            default: r = 32'hFFFF_FFFF;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/vufc_mul.sv
// Shared signed 33 by 33 bit multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module vufc_mul (
    input  logic           i_clk,
    input  vufc_pkg::t_op  i_a,
    input  vufc_pkg::t_op  i_b,
    output vufc_pkg::t_prod o_prod
);
    import vufc_pkg::*;

    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: hw/rtl/vufc_div.sv
// Unsigned restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module vufc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vufc_pkg::t_div_req i_req,
    output vufc_pkg::t_div_rsp o_rsp
);
    import vufc_pkg::*;

    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_DW:0]   rem_sh;
    logic              fits;
    logic [DIV_DW:0]   rem_nx;

    assign rem_sh = {r_rem, r_quo[DIV_NW-1]};
    assign fits   = (rem_sh >= {1'b0, r_den});
    assign rem_nx = fits ? (rem_sh - {1'b0, r_den}) : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_CW'(DIV_NW);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == DIV_CW'(1));
            r_busy <= (r_cnt != DIV_CW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den <= i_req.den;
            r_rem <= '0;
            r_quo <= i_req.num;
        end else if (r_busy) begin
            r_rem <= rem_nx[DIV_DW-1:0];
            r_quo <= {r_quo[DIV_NW-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

`default_nettype wire

// File: hw/rtl/variable_universe_fuzzy_controller_core.sv
// Top level of the variable-universe fuzzy force controller: sequencer, state and registers.
`timescale 1ns / 1ps
`default_nettype none

// Each input transaction carries one axis's target and measured velocity in signed Q16.16
// and yields exactly one output transaction with the force command for that axis. The
// block works on one transaction at a time: o_in_ready is high only while the sequencer
// waits for work, and a finished result sits in an output register, so the next input
// is taken while the result still waits for i_out_ready. The transaction time is set by
// the single restoring divider, which shifts out the 61-bit quotient and is used up
// to five times per transaction, and by the single registered multiplier, which evaluates
// four exponentials as a 12-step series plus one multiply by exp(-1) for each whole unit
// of the exponent. An exponent of sixteen or more whole units skips the series, and a
// vanished contraction factor skips its divide. An axis index at or beyond the axis count
// is answered with a zero force and leaves the per-axis state untouched. After reset the
// block computes exp(-1) with the same multiplier before it raises o_in_ready;
// configuration writes are taken at any time and take effect at once.
module variable_universe_fuzzy_controller_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vufc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vufc_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import vufc_pkg::*;

    // Configuration registers.
    logic [16:0]        r_gamma;
    logic [16:0]        r_lambda;
    logic [30:0]        r_slope;
    logic [30:0]        r_ki;
    logic signed [31:0] r_p0;
    logic signed [31:0] r_p1;
    logic [30:0]        r_isp;

    // Per-axis state.
    logic signed [31:0] r_prior [AXES];
    logic signed [31:0] r_dsum  [AXES];

    // Sequencer and datapath registers.
    t_state             r_state, n_state;
    t_call              r_call,  n_call;
    logic [2:0]         r_axis,  n_axis;
    logic signed [31:0] r_e,     n_e;
    logic signed [31:0] r_d,     n_d;
    logic signed [31:0] r_x,     n_x;
    logic signed [31:0] r_ec,    n_ec;
    logic signed [31:0] r_dc,    n_dc;
    logic signed [31:0] r_t1,    n_t1;
    logic signed [31:0] r_t2,    n_t2;
    logic [30:0]        r_f,     n_f;
    logic [30:0]        r_t,     n_t;
    logic [30:0]        r_p,     n_p;
    logic [3:0]         r_k,     n_k;
    logic [3:0]         r_cnt,   n_cnt;
    logic [30:0]        r_e1,    n_e1;
    logic               r_ysign, n_ysign;
    logic               r_qneg,  n_qneg;
    t_wide              r_acc,   n_acc;
    logic signed [19:0] r_fs,    n_fs;
    logic signed [31:0] r_q,     n_q;
    logic signed [31:0] r_res,   n_res;
    t_out_item          r_out;
    logic               r_ovalid;

    logic               in_ready;
    logic               st_we;
    logic               out_load;
    t_op                mul_a;
    t_op                mul_b;
    t_prod              r_prod;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    // Derived values used by the sequencer.
    logic [AX_IW-1:0]   idx;
    logic               axis_bad;
    logic signed [31:0] in_err;
    logic signed [31:0] prior_rd;
    logic signed [31:0] dsum_rd;
    logic signed [31:0] ediff_sat;
    logic signed [31:0] dsum_new;
    t_wide              prod_w;
    t_wide              rnd16_w;
    logic [31:0]        x_mag;
    logic signed [31:0] y_w;
    logic [31:0]        y_mag;
    logic [32:0]        u_w;
    logic [30:0]        p_w;
    logic [30:0]        q0_w;
    logic [34:0]        qk_w;
    logic [34:0]        rem_w;
    logic [30:0]        qc_w;
    logic [30:0]        t_new;
    t_wide              ge_w;
    logic signed [18:0] alpha_w;
    logic [18:0]        alpha_mag;
    t_wide              fs_w;
    logic signed [31:0] beta_s;
    logic signed [31:0] beta_w;
    logic [31:0]        beta_mag;
    logic [19:0]        fs_mag;
    logic [30:0]        tq_w;
    logic signed [31:0] tanh_w;

    vufc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (r_prod)
    );

    vufc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign idx       = AX_IW'(r_axis);
    assign axis_bad  = (5'(i_in_data.axis) >= 5'(AXES));
    assign in_err    = f_sat32(t_wide'(i_in_data.target_vel)
                               - t_wide'(i_in_data.measured_vel));
    assign prior_rd  = r_prior[idx];
    assign dsum_rd   = r_dsum[idx];
    assign ediff_sat = f_sat32(t_wide'(r_e) - t_wide'(prior_rd));
    assign dsum_new  = f_sat32(t_wide'(dsum_rd) + t_wide'(r_d));

    assign prod_w    = t_wide'(r_prod);
    assign rnd16_w   = f_rnd16(prod_w);
    assign x_mag     = r_x[31] ? 32'(-r_x) : 32'(r_x);

    // Scaled tanh argument and the exponent 2|y| it feeds.
    assign y_w       = f_sat32(rnd16_w);
    assign y_mag     = y_w[31] ? 32'(-y_w) : 32'(y_w);
    assign u_w       = {y_mag, 1'b0};

    // One series step: t = 1 - floor(f*t) / k, the division done by reciprocal and
    // a single correction.
    assign p_w       = r_prod[60:30];
    assign q0_w      = r_prod[62:32];
    assign qk_w      = 35'(q0_w) * 35'(r_k);
    assign rem_w     = 35'(r_p) - qk_w;
    assign qc_w      = (rem_w >= 35'(r_k)) ? (q0_w + 31'd1) : q0_w;
    assign t_new     = Q30_ONE - qc_w;

    // Contraction factor 1 - gamma*exp in Q16.16.
    assign ge_w      = f_rnd30(prod_w);
    assign alpha_w   = 19'sd65536 - $signed(ge_w[18:0]);
    assign alpha_mag = alpha_w[18] ? 19'(-alpha_w) : 19'(alpha_w);

    assign fs_w      = f_rnd30(r_acc + prod_w);
    assign fs_mag    = r_fs[19] ? 20'(-r_fs) : 20'(r_fs);
    assign beta_s    = f_sat32(r_acc + rnd16_w);
    assign beta_w    = (beta_s == 32'sd0) ? 32'sd1 : beta_s;
    assign beta_mag  = beta_w[31] ? 32'(-beta_w) : 32'(beta_w);

    assign tq_w      = div_rsp.quot[30:0];
    assign tanh_w    = r_qneg ? -$signed(32'(tq_w)) : $signed(32'(tq_w));

    always_comb begin
        n_state  = r_state;
        n_call   = r_call;
        n_axis   = r_axis;
        n_e      = r_e;
        n_d      = r_d;
        n_x      = r_x;
        n_ec     = r_ec;
        n_dc     = r_dc;
        n_t1     = r_t1;
        n_t2     = r_t2;
        n_f      = r_f;
        n_t      = r_t;
        n_p      = r_p;
        n_k      = r_k;
        n_cnt    = r_cnt;
        n_e1     = r_e1;
        n_ysign  = r_ysign;
        n_qneg   = r_qneg;
        n_acc    = r_acc;
        n_fs     = r_fs;
        n_q      = r_q;
        n_res    = r_res;
        in_ready = 1'b0;
        st_we    = 1'b0;
        out_load = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        div_req  = '0;

        unique case (r_state)
            ST_INIT: begin
                // exp(-1) from the series at f = 1, kept for the whole-unit steps.
                n_f     = Q30_ONE;
                n_t     = Q30_ONE;
                n_k     = HORNER_TERMS;
                n_call  = CALL_INIT;
                n_state = ST_HMUL;
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in_valid) begin
                    n_axis = i_in_data.axis;
                    n_e    = in_err;
                    if (axis_bad) begin
                        n_res   = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_DMUL;
                    end
                end
            end
            ST_DMUL: begin
                mul_a   = 33'(ediff_sat);
                mul_b   = $signed({2'b0, r_isp});
                n_state = ST_DUSE;
            end
            ST_DUSE: begin
                n_d     = f_sat32(rnd16_w);
                n_state = ST_DSUM;
            end
            ST_DSUM: begin
                st_we   = 1'b1;
                n_x     = r_e;
                n_call  = CALL_CE;
                n_state = ST_SQ;
            end
            ST_SQ: begin
                mul_a   = $signed({1'b0, x_mag});
                mul_b   = $signed({1'b0, x_mag});
                n_state = ST_SQUSE;
            end
            ST_SQUSE: begin
                // Exponent x*x/2 in Q16.16; sixteen or more whole units give zero.
                if (|r_prod[65:37]) begin
                    n_t     = '0;
                    n_state = ST_EXP_RET;
                end else begin
                    n_f     = {1'b0, r_prod[32:17], 14'b0};
                    n_cnt   = r_prod[36:33];
                    n_k     = HORNER_TERMS;
                    n_t     = Q30_ONE;
                    n_state = ST_HMUL;
                end
            end
            ST_TMUL: begin
                mul_a   = $signed({2'b0, r_slope});
                mul_b   = (r_call == CALL_T1) ? 33'(r_ec) : 33'(r_dc);
                n_state = ST_TUSE;
            end
            ST_TUSE: begin
                n_ysign = y_w[31];
                if (|u_w[32:20]) begin
                    n_t     = '0;
                    n_state = ST_EXP_RET;
                end else begin
                    n_f     = {1'b0, u_w[15:0], 14'b0};
                    n_cnt   = u_w[19:16];
                    n_k     = HORNER_TERMS;
                    n_t     = Q30_ONE;
                    n_state = ST_HMUL;
                end
            end
            ST_HMUL: begin
                mul_a   = $signed({2'b0, r_f});
                mul_b   = $signed({2'b0, r_t});
                n_state = ST_HREC;
            end
            ST_HREC: begin
                n_p     = p_w;
                mul_a   = $signed({2'b0, p_w});
                mul_b   = $signed({1'b0, f_recip(r_k)});
                n_state = ST_HCORR;
            end
            ST_HCORR: begin
                n_t = t_new;
                if (r_k == 4'd1) begin
                    if (r_call == CALL_INIT) begin
                        n_e1    = t_new;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_EXPN;
                    end
                end else begin
                    n_k     = r_k - 4'd1;
                    n_state = ST_HMUL;
                end
            end
            ST_EXPN: begin
                if (r_cnt == 4'd0) begin
                    n_state = ST_EXP_RET;
                end else begin
                    mul_a   = $signed({2'b0, r_t});
                    mul_b   = $signed({2'b0, r_e1});
                    n_state = ST_EXPNUSE;
                end
            end
            ST_EXPNUSE: begin
                n_t     = p_w;
                n_cnt   = r_cnt - 4'd1;
                n_state = ST_EXPN;
            end
            ST_EXP_RET: begin
                if (r_call == CALL_CE || r_call == CALL_CD) begin
                    n_state = ST_GMUL;
                end else begin
                    n_state = ST_TDIV;
                end
            end
            ST_GMUL: begin
                mul_a   = $signed({16'b0, r_gamma});
                mul_b   = $signed({2'b0, r_t});
                n_state = ST_GUSE;
            end
            ST_GUSE: begin
                if (alpha_w == 19'sd0) begin
                    // A vanished universe saturates the signal by its sign.
                    if (r_x == 32'sd0) begin
                        n_q = 32'sd0;
                    end else begin
                        n_q = r_x[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end
                    n_state = ST_CRET;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_NW'({x_mag, 16'b0});
                    div_req.den   = DIV_DW'(alpha_mag);
                    n_qneg        = r_x[31] ^ alpha_w[18];
                    n_state       = ST_CDIV;
                end
            end
            ST_CDIV: begin
                if (div_rsp.done) begin
                    n_q     = f_sgn_sat(div_rsp.quot, r_qneg);
                    n_state = ST_CRET;
                end
            end
            ST_CRET: begin
                if (r_call == CALL_CE) begin
                    n_ec    = r_q;
                    n_x     = r_d;
                    n_call  = CALL_CD;
                    n_state = ST_SQ;
                end else begin
                    n_dc    = r_q;
                    n_call  = CALL_T1;
                    n_state = ST_TMUL;
                end
            end
            ST_TDIV: begin
                div_req.start = 1'b1;
                div_req.num   = {(Q30_ONE - r_t), 30'b0};
                div_req.den   = 32'(Q30_ONE) + 32'(r_t);
                n_qneg        = r_ysign;
                n_state       = ST_TWAIT;
            end
            ST_TWAIT: begin
                if (div_rsp.done) begin
                    if (r_call == CALL_T1) begin
                        n_t1    = tanh_w;
                        n_call  = CALL_T2;
                        n_state = ST_TMUL;
                    end else begin
                        n_t2    = tanh_w;
                        n_state = ST_BMUL1;
                    end
                end
            end
            ST_BMUL1: begin
                mul_a   = $signed({16'b0, r_lambda});
                mul_b   = 33'(r_t1);
                n_state = ST_BMUL2;
            end
            ST_BMUL2: begin
                n_acc   = prod_w;
                mul_a   = 33'sd65536 - $signed({16'b0, r_lambda});
                mul_b   = 33'(r_t2);
                n_state = ST_BUSE;
            end
            ST_BUSE: begin
                n_fs    = fs_w[19:0];
                n_state = ST_PMUL1;
            end
            ST_PMUL1: begin
                mul_a   = 33'(r_p0);
                mul_b   = 33'(r_e);
                n_state = ST_PMUL2;
            end
            ST_PMUL2: begin
                n_acc   = rnd16_w;
                mul_a   = 33'(r_p1);
                mul_b   = 33'(r_d);
                n_state = ST_PUSE;
            end
            ST_PUSE: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'({fs_mag, 16'b0});
                div_req.den   = beta_mag;
                n_qneg        = r_fs[19] ^ beta_w[31];
                n_state       = ST_QWAIT;
            end
            ST_QWAIT: begin
                if (div_rsp.done) begin
                    n_q     = f_sgn_sat(div_rsp.quot, r_qneg);
                    n_state = ST_KMUL;
                end
            end
            ST_KMUL: begin
                mul_a   = $signed({2'b0, r_ki});
                mul_b   = 33'(dsum_rd);
                n_state = ST_KUSE;
            end
            ST_KUSE: begin
                n_res   = f_sat32(t_wide'(r_q) + rnd16_w);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_call   <= CALL_INIT;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_call  <= n_call;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_axis  <= n_axis;
        r_e     <= n_e;
        r_d     <= n_d;
        r_x     <= n_x;
        r_ec    <= n_ec;
        r_dc    <= n_dc;
        r_t1    <= n_t1;
        r_t2    <= n_t2;
        r_f     <= n_f;
        r_t     <= n_t;
        r_p     <= n_p;
        r_k     <= n_k;
        r_cnt   <= n_cnt;
        r_e1    <= n_e1;
        r_ysign <= n_ysign;
        r_qneg  <= n_qneg;
        r_acc   <= n_acc;
        r_fs    <= n_fs;
        r_q     <= n_q;
        r_res   <= n_res;
        if (out_load) begin
            r_out.axis_out  <= r_axis;
            r_out.force_res <= r_res;
        end
    end

    // The previous error and the derivative sum of an axis change together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_prior[i] <= '0;
                r_dsum[i]  <= '0;
            end
        end else if (st_we) begin
            r_prior[idx] <= r_e;
            r_dsum[idx]  <= dsum_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma  <= 17'd55706;
            r_lambda <= 17'd32768;
            r_slope  <= 31'd6554;
            r_ki     <= 31'd6553600;
            r_p0     <= 32'sd32768;
            r_p1     <= 32'sd32768;
            r_isp    <= 31'd65536000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAMMA:  r_gamma  <= i_cfg_data[16:0];
                CFG_LAMBDA: r_lambda <= i_cfg_data[16:0];
                CFG_SLOPE:  r_slope  <= i_cfg_data[30:0];
                CFG_KI:     r_ki     <= i_cfg_data[30:0];
                CFG_P0:     r_p0     <= $signed(i_cfg_data);
                CFG_P1:     r_p1     <= $signed(i_cfg_data);
                CFG_ISP:    r_isp    <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // A transaction is taken only once; the sequencer is busy right after it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again right after a transaction");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_CDIV || r_state == ST_TWAIT || r_state == ST_QWAIT))
        else $error("divider result arrived outside a wait state");

    // The series index stays within its terms, so the reciprocal is always valid.
    a_series_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HMUL) |-> (r_k != 4'd0 && r_k <= HORNER_TERMS))
        else $error("series step index out of range");

endmodule

`default_nettype wire
